[rtl/bda_pkg.sv]
package bda_pkg;

  localparam int VALUE_W  = 16;
  localparam int DIG_W    = 4;
  localparam int DIGITS   = 5;
  localparam int BCD_W    = DIG_W * DIGITS;
  localparam int CHAR_W   = 6;
  localparam int TOTAL_W  = 3;
  localparam int STEP_W   = 4;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'd48;
  localparam logic [STEP_W-1:0]  LAST_STEP  = 4'd15;
  localparam logic [DIG_W-1:0]   ADJ_LIMIT  = 4'd5;
  localparam logic [DIG_W-1:0]   ADJ_ADD    = 4'd3;

  // front converter states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_PUSH
  } bda_state_t;

  // one converted value waiting in the queue
  typedef struct packed {
    logic [BCD_W-1:0]   bcd;
    logic [TOTAL_W-1:0] total;
  } bda_entry_t;

  // handshake between two stages carrying an entry
  typedef struct packed {
    logic       valid;
    bda_entry_t entry;
  } bda_link_t;

endpackage

[rtl/bda_conv.sv]
module bda_conv (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [bda_pkg::IN_TDATA_W-1:0] in_tdata,
  output bda_pkg::bda_link_t             push,
  input  logic                           push_ready
);
  import bda_pkg::*;

  bda_state_t         state_r, state_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [VALUE_W-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0]   bcd_r, bcd_nxt;
  logic [BCD_W-1:0]   bcd_adj;
  logic [TOTAL_W-1:0] total;
  logic               accept;

  // add-3 correction on every digit before the shift
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_r[i*DIG_W +: DIG_W] >= ADJ_LIMIT) begin
        bcd_adj[i*DIG_W +: DIG_W] = bcd_r[i*DIG_W +: DIG_W] + ADJ_ADD;
      end else begin
        bcd_adj[i*DIG_W +: DIG_W] = bcd_r[i*DIG_W +: DIG_W];
      end
    end
  end

  // digit count from the highest nonzero digit, zero still shows one digit
  always_comb begin
    priority if (bcd_r[4*DIG_W +: DIG_W] != '0) begin
      total = 3'd5;
    end else if (bcd_r[3*DIG_W +: DIG_W] != '0) begin
      total = 3'd4;
    end else if (bcd_r[2*DIG_W +: DIG_W] != '0) begin
      total = 3'd3;
    end else if (bcd_r[1*DIG_W +: DIG_W] != '0) begin
      total = 3'd2;
    end else begin
      total = 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    bin_r  <= bin_nxt;
    bcd_r  <= bcd_nxt;
  end

  always_comb begin
    state_nxt        = state_r;
    step_nxt         = step_r;
    bin_nxt          = bin_r;
    bcd_nxt          = bcd_r;
    in_tready        = 1'b0;
    push.valid       = 1'b0;
    push.entry.bcd   = bcd_r;
    push.entry.total = total;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          bin_nxt   = in_tdata[VALUE_W-1:0];
          bcd_nxt   = '0;
          step_nxt  = '0;
          state_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        {bcd_nxt, bin_nxt} = {bcd_adj[BCD_W-2:0], bin_r, 1'b0};
        step_nxt = step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        push.valid = 1'b1;
        if (push_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign accept = in_tvalid && in_tready;

  // the shift loop always takes sixteen steps before the queue write
  a_push_timing: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##17 push.valid)
    else $error("conversion did not reach queue write after 16 shifts");

endmodule

[rtl/bda_fifo.sv]
module bda_fifo #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bda_pkg::bda_link_t push,
  output logic               push_ready,
  output bda_pkg::bda_link_t head,
  input  logic               pop
);
  import bda_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bda_entry_t     mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop && (count_r != '0);
  assign head.valid = (count_r != '0);
  assign head.entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.entry;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid)
    else $error("pop from empty queue");

endmodule

[rtl/bda_emit.sv]
module bda_emit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bda_pkg::bda_link_t              head,
  output logic                            pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bda_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast
);
  import bda_pkg::*;

  logic               busy_r, busy_nxt;
  logic [BCD_W-1:0]   bcd_r;
  logic [TOTAL_W-1:0] total_r;
  logic [TOTAL_W-1:0] pos_r;
  logic               out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]  out_char_r;
  logic [TOTAL_W-1:0] out_total_r;
  logic               out_last_r;
  logic               load, emit;
  logic [DIG_W-1:0]   digit;

  assign load = !busy_r && head.valid;
  assign emit = busy_r && (!out_valid_r || out_tready);
  assign pop  = load;

  // digit at the current position, counted from the least significant
  always_comb begin
    unique case (pos_r)
      3'd0:    digit = bcd_r[0*DIG_W +: DIG_W];
      3'd1:    digit = bcd_r[1*DIG_W +: DIG_W];
      3'd2:    digit = bcd_r[2*DIG_W +: DIG_W];
      3'd3:    digit = bcd_r[3*DIG_W +: DIG_W];
      3'd4:    digit = bcd_r[4*DIG_W +: DIG_W];
      default: digit = '0;
    endcase
  end

  always_comb begin
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      busy_nxt = 1'b1;
    end else if (emit && pos_r == '0) begin
      busy_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bcd_r   <= head.entry.bcd;
      total_r <= head.entry.total;
      pos_r   <= head.entry.total - 3'd1;
    end else if (emit) begin
      pos_r   <= pos_r - 3'd1;
    end
    if (emit) begin
      out_char_r  <= ASCII_ZERO + CHAR_W'(digit);
      out_total_r <= total_r;
      out_last_r  <= (pos_r == '0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_TDATA_W - TOTAL_W - CHAR_W){1'b0}}, out_total_r, out_char_r};

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_char_r >= ASCII_ZERO) && (out_char_r <= ASCII_ZERO + 6'd9))
    else $error("digit character outside decimal range");

endmodule

[rtl/binary_to_decimal_ascii.sv]
// channel | direction | ports                      | word contents
// in      | slave     | in_tvalid/in_tready/in_tdata | value [15:0]
// out     | master    | out_tvalid/out_tready/out_tdata/out_tlast
//         |           |   | digit_char [5:0], digit_total [8:6], last_digit on tlast
//
// the front converter takes one value at a time: one accept in idle, sixteen
// shift-and-add-3 steps, one queue write that waits for room; that loop sets
// the sustained rate; the back end emits one digit per cycle, most significant
// first, while the output is not stalled, with a load gap between values
// reset (rst_n low, synchronous) empties the queue and drops any partial work
// output stalls fill the queue and then hold the front; input idles only
// starve the back end
module binary_to_decimal_ascii #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input words
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [bda_pkg::IN_TDATA_W-1:0]  in_tdata,   // [15:0] value
  // result words, one per digit
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bda_pkg::OUT_TDATA_W-1:0] out_tdata,  // [5:0] digit_char, [8:6] digit_total
  output logic                            out_tlast   // last digit of the value
);
  import bda_pkg::*;

  bda_link_t push;   // converter to queue
  bda_link_t head;   // queue head to digit emitter
  logic      push_ready;
  logic      pop;

  // double-dabble front end
  bda_conv u_conv (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .push       (push),
    .push_ready (push_ready)
  );

  // short queue of converted values so front and back stall separately
  bda_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .head       (head),
    .pop        (pop)
  );

  // digit serializer with registered output
  bda_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
